### design/rdf_pkg.sv
// package with shared constants, types and helper functions of the radix digit formatter
`default_nettype none
package rdf_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned MAX_DIGITS_DEF = 32;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d >= DIGIT_TEN) begin
      res = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      res = CHAR_ZERO + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### design/rdf_if.sv
// valid/ready channel interfaces for the input and result requests
`default_nettype none
interface rdf_in_if import rdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdf_out_if import rdf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface
`default_nettype wire

### design/rdf_divider.sv
// bit-serial restoring divider by a small radix, one quotient bit per cycle
`default_nettype none
module rdf_divider import rdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire div_req_t              req_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  output logic                       done_o,
  output logic [VALUE_BITS-1:0]      quotient_o,
  output logic [DIGIT_W-1:0]         remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS-1:0] num_q, num_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q;
  logic [RADIX_W-1:0]    trial;
  logic [RADIX_W-1:0]    diff;
  logic                  ge;
  logic                  start;

  assign start = req_i.start && !busy_q;

  always_comb begin
    trial = {rem_q, num_q[VALUE_BITS-1]};
    ge    = (trial >= div_q);
    diff  = trial - div_q;
    rem_d = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    num_d = {num_q[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = num_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

### design/rdf_digit_buf.sv
// digit store memory with one write port and one registered read port
`default_nettype none
module rdf_digit_buf import rdf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MAX_DIGITS)-1:0] wr_addr_i,
  input  wire logic [DIGIT_W-1:0]            wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(MAX_DIGITS)-1:0] rd_addr_i,
  output logic [DIGIT_W-1:0]                 rd_data_o
);

  logic [DIGIT_W-1:0] mem_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### design/radix_digit_formatter.sv
// top level: sequencer around the shared divider and the digit store
// each digit is one divider pass; each digit out goes through ST_READ, then ST_SHOW
// a new request is taken only once every digit of the last one has left;
//   the bit-serial divider is reused for every digit
// input ready only while idle; results leave most significant digit first
// reset: asynchronous active low, returns to idle; the digit store is not cleared
`default_nettype none
module radix_digit_formatter import rdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdf_in_if.sink    in_i,
  rdf_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e                state_q;
  logic [AW-1:0]         count_q;
  logic [AW-1:0]         idx_q;
  logic [RADIX_W-1:0]    radix_q;

  div_req_t              div_req;
  logic [VALUE_BITS-1:0] dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  logic [DIGIT_W-1:0]    remainder;
  logic [DIGIT_W-1:0]    rd_data;

  logic                  in_acc;
  logic                  wr_en;
  logic                  more;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign wr_en      = (state_q == ST_DIV) && div_done;
  assign more       = (quotient != '0) && (count_q != AW'(MAX_DIGITS - 1));

  always_comb begin
    div_req.start   = in_acc || (wr_en && more);
    div_req.divisor = in_acc ? clamp_radix(in_i.radix) : radix_q;
    dividend        = in_acc ? in_i.value : quotient;
  end

  rdf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (dividend),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  rdf_digit_buf #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digit_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q),
    .wr_data_i (remainder),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      radix_q <= RADIX_MIN;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            radix_q <= clamp_radix(in_i.radix);
            count_q <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (more) begin
              count_q <= count_q + 1'b1;
            end else begin
              idx_q   <= count_q;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_o.ready) begin
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = (state_q == ST_SHOW);
  assign out_o.digit_char = digit_to_ascii(rd_data);
  assign out_o.last       = (idx_q == '0);

endmodule
`default_nettype wire

### design/rdf_checker.sv
// port-level checker for the radix digit formatter and its bind
`default_nettype none
module rdf_checker import rdf_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [CHAR_W-1:0] out_char_i,
  input wire logic              out_last_i
);

  // results and new requests never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  // busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready in the cycle after a request");

  // every taken digit is followed by a gap for the store read or by idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> !out_valid_i)
    else $error("result valid right after a taken digit");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_char_i) && $stable(out_last_i)))
    else $error("stalled result changed");

endmodule

bind radix_digit_formatter rdf_checker u_rdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.digit_char),
  .out_last_i  (out_o.last)
);
`default_nettype wire

### tb/rdf_digit_checker.sv
// checker: predicts the digit string of each accepted request and compares the results
`timescale 1ns / 1ps
module rdf_digit_checker import rdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  rdf_in_if    in_mon,
  rdf_out_if   out_mon,
  output int   err_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  digit_t digit_q[$];
  digit_t want;

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t digit check: %s", $time, msg);
    err_cnt_o++;
  endtask

  function automatic void queue_digits(input logic [VALUE_BITS-1:0] v,
                                       input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] rems [MAX_DIGITS];
    logic [63:0]        q;
    logic [DIGIT_W-1:0] dg;
    digit_t             d;
    int                 n;
    base = r;
    if (r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    q = 64'(v);
    n = 0;
    if (q == 0) begin
      rems[0] = '0;
      n = 1;
    end else begin
      while (q != 0 && n < MAX_DIGITS) begin
        rems[n] = DIGIT_W'(q % 64'(base));
        q = q / 64'(base);
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      dg = rems[n - 1 - k];
      if (dg >= DIGIT_TEN) begin
        d.ch = CHAR_A + CHAR_W'(dg - DIGIT_TEN);
      end else begin
        d.ch = CHAR_ZERO + CHAR_W'(dg);
      end
      d.last = (k == n - 1);
      digit_q.push_back(d);
    end
  endfunction

  // results first: a request accepted in the same cycle cannot own them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (digit_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digit %h last %b",
                                    out_mon.digit_char, out_mon.last));
        end else begin
          want = digit_q.pop_front();
          if (out_mon.digit_char !== want.ch) begin
            report_mismatch($sformatf("digit_char %h, want %h",
                                      out_mon.digit_char, want.ch));
          end
          if (out_mon.last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b", out_mon.last, want.last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        queue_digits(in_mon.value, in_mon.radix);
      end
    end
    pending_o = digit_q.size();
  end

endmodule

### tb/tb_top.sv
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_top;
  import rdf_pkg::*;

  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int unsigned MAX_DIGITS = MAX_DIGITS_DEF;
  localparam int          NUM_RANDOM = 200;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;
  int   cyc = 0;
  int   err_cnt;
  int   pending;

  rdf_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  rdf_out_if out_ch ();

  radix_digit_formatter #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rdf_digit_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && (calm || $urandom_range(0, 99) >= 21);
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.value = v;
    in_ch.radix = r;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_all_digits();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_W-1:0]    r;
    int                    mode;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero value, clamping at both ends, longest strings, letter digits
    send_number('0, 5'd10);
    send_number('0, 5'd0);
    send_number(VALUE_MAX, 5'd2);
    send_number(VALUE_MAX, 5'd0);
    send_number(VALUE_MAX, 5'd1);
    send_number(VALUE_MAX, 5'd16);
    send_number(VALUE_MAX, 5'd17);
    send_number(VALUE_MAX, 5'd31);
    send_number(VALUE_MAX, 5'd3);
    send_number(VALUE_MAX, 5'd10);
    send_number(VALUE_BITS'(1), 5'd2);
    send_number(VALUE_BITS'(9), 5'd10);
    send_number(VALUE_BITS'(10), 5'd16);
    send_number(VALUE_BITS'(15), 5'd16);
    send_number(VALUE_BITS'(255), 5'd16);
    send_number(VALUE_BITS'(12345), 5'd10);
    send_number(VALUE_BITS'(32'h2AAA_AAAA), 5'd8);
    send_number(VALUE_BITS'(32'h5555_5555), 5'd7);
    send_number(VALUE_BITS'(32'h4000_0000), 5'd4);
    send_number(VALUE_BITS'(32'h1234_5678), 5'd15);
    send_number(VALUE_BITS'(32'h7ABC_DEF0), 5'd16);
    wait_all_digits();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 80 && i < 120);
      mode = $urandom_range(0, 9);
      case (mode)
        0: v = '0;
        1, 2: v = VALUE_BITS'($urandom_range(0, 999));
        3, 4: v = VALUE_BITS'($urandom()) >> $urandom_range(0, VALUE_BITS - 1);
        default: v = VALUE_BITS'($urandom());
      endcase
      r = RADIX_W'($urandom_range(0, 31));
      send_number(v, r);
      if (i == 150 || $urandom_range(0, 39) == 0) begin
        wait_all_digits();
      end
    end
    calm = 1'b0;

    wait_all_digits();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/rdf_pkg.sv
design/rdf_if.sv
design/rdf_divider.sv
design/rdf_digit_buf.sv
design/radix_digit_formatter.sv
design/rdf_checker.sv
tb/rdf_digit_checker.sv
tb/tb_top.sv
